>>> rtl/core/wfg_pkg.sv
// wfg_pkg: shared types and constants of the wait-for graph deadlock detector
// no dependencies
package wfg_pkg;
    localparam int NODES = 32;
    localparam int ID_W = $clog2(NODES);
    localparam int CNT_W = $clog2(NODES + 1);
    localparam logic [31:0] PRIO_ABSENT = 32'h8000_0000;

    typedef enum logic [2:0] {
        K_CLEAR  = 3'd0,
        K_ADD    = 3'd1,
        K_REMOVE = 3'd2,
        K_PRIO   = 3'd3,
        K_DETECT = 3'd4
    } t_kind;

    typedef struct packed {
        logic [2:0]         kind;
        logic [4:0]         waiter;
        logic [4:0]         holder;
        logic signed [31:0] priority_req;
    } t_in;

    typedef struct packed {
        logic               is_victim;
        logic [4:0]         victim_id;
        logic signed [31:0] victim_priority;
        logic [5:0]         cycle_count;
        logic               last;
    } t_out;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLR,
        S_EDGE_RD,
        S_EDGE_WR,
        S_PRIO_WR,
        S_START,
        S_TOP_RD,
        S_TOP_EV,
        S_CYC_RD,
        S_CYC_EV,
        S_EMIT,
        S_DEL,
        S_DEL_RD,
        S_DEL_WR,
        S_FINAL,
        S_OUT
    } t_state;
endpackage

>>> rtl/core/wait_for_graph_deadlock_detector.sv
// wait_for_graph_deadlock_detector: top level of the deadlock detector
// depends on wfg_pkg and wfg_detector
//
// Input beats carry kind, waiter, holder and priority_req. Only one item is
// in flight; o_ready is high only while the sequencer is idle. Clear walks
// the adjacency memory one row a cycle. An edge update reads the waiter's
// row and writes it back; a priority write is a single write state and an
// unused kind is dropped in idle. A detection run does a depth first search
// with a start step per root (S_START) and one adjacency read per stack step
// (S_TOP_RD, S_TOP_EV), then scans the cycle members (S_CYC_RD, S_CYC_EV)
// for the victim, emits it and walks all rows to strip its edges. Each
// victim is one result beat and a final beat carries the cycle count with
// last set. After reset a pass with o_ready low clears every edge and marks
// every priority absent. i_ready low holds the pending result beat and
// stalls the sequencer when it has a new beat to load, and no input is
// taken until the final beat has been loaded.
module wait_for_graph_deadlock_detector (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  wfg_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output wfg_pkg::t_out o_data
);
    import wfg_pkg::*;

    wfg_detector u_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );
endmodule

>>> rtl/core/wfg_detector.sv
// wfg_detector: graph update and cycle search sequencer over the adjacency
// and priority memories; depends on wfg_pkg
module wfg_detector (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  wfg_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output wfg_pkg::t_out o_data
);
    import wfg_pkg::*;

    // adjacency and priority memories, one port each, registered read
    logic [NODES-1:0] r_adj [NODES];
    logic [31:0]      r_prio [NODES];
    logic [NODES-1:0] r_adj_q;
    logic [31:0]      r_prio_q;
    // stack of path nodes and the neighbor cursor of each level
    logic [ID_W-1:0]  r_stk [NODES];
    logic [ID_W:0]    r_cur [NODES];

    t_state r_st, n_st;
    t_in    r_in;
    logic [NODES-1:0] r_vis, r_onp;
    logic [ID_W:0]    r_len;
    logic [ID_W:0]    r_start;
    logic [ID_W:0]    r_i;
    logic [ID_W:0]    r_cyc0;
    logic [ID_W-1:0]  r_victim;
    logic [31:0]      r_best;
    logic [CNT_W-1:0] r_cnt;
    t_out             r_out;
    logic             r_ovalid;
    logic             r_init;

    logic             adj_we, prio_rd;
    logic [ID_W-1:0]  adj_addr;
    logic [NODES-1:0] adj_wd;
    logic             out_load;

    logic [ID_W-1:0]  top;
    logic [ID_W:0]    cur;
    logic [NODES-1:0] masked;
    logic             found;
    logic [ID_W-1:0]  nb;
    logic [ID_W:0]    first_idx;

    assign top = r_stk[r_len[ID_W-1:0] - 1'b1];
    assign cur = r_cur[r_len[ID_W-1:0] - 1'b1];

    always_comb begin
        masked = r_adj_q;
        for (int k = 0; k < NODES; k++) begin
            if (k < cur) masked[k] = 1'b0;
        end
        found = |masked;
        nb = '0;
        for (int k = NODES - 1; k >= 0; k--) begin
            if (masked[k]) nb = k[ID_W-1:0];
        end
        // stack position where the found loop closes
        first_idx = '0;
        for (int k = NODES - 1; k >= 0; k--) begin
            if ((ID_W+1)'(k) < r_len && r_stk[k] == nb) first_idx = (ID_W+1)'(k);
        end
    end

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_data.kind)
                        K_CLEAR:  n_st = S_CLR;
                        K_ADD, K_REMOVE: n_st = S_EDGE_RD;
                        K_PRIO:   n_st = S_PRIO_WR;
                        K_DETECT: n_st = S_START;
                        default:  n_st = S_IDLE;
                    endcase
                end
            end
            S_CLR:     n_st = (r_i == (ID_W+1)'(NODES - 1)) ? S_IDLE : S_CLR;
            S_EDGE_RD: n_st = S_EDGE_WR;
            S_EDGE_WR: n_st = S_IDLE;
            S_PRIO_WR: n_st = S_IDLE;
            S_START: begin
                if (r_len != '0) n_st = S_TOP_RD;
                else if (r_start == (ID_W+1)'(NODES)) n_st = S_FINAL;
                else n_st = S_START;
            end
            S_TOP_RD:  n_st = S_TOP_EV;
            S_TOP_EV: begin
                if (!found) n_st = (r_len == 1) ? S_START : S_TOP_RD;
                else if (!r_vis[nb]) n_st = S_TOP_RD;
                else if (r_onp[nb]) n_st = S_CYC_RD;
                else n_st = S_TOP_RD;
            end
            S_CYC_RD:  n_st = S_CYC_EV;
            S_CYC_EV:  n_st = (r_i + 1'b1 == r_len) ? S_EMIT : S_CYC_RD;
            S_EMIT:    n_st = i_ready || !r_ovalid ? S_DEL : S_EMIT;
            S_DEL:     n_st = S_DEL_RD;
            S_DEL_RD:  n_st = S_DEL_WR;
            S_DEL_WR: begin
                if (r_i == (ID_W+1)'(NODES - 1))
                    n_st = (r_cnt == CNT_W'(NODES)) ? S_FINAL : S_START;
                else n_st = S_DEL_RD;
            end
            S_FINAL:   n_st = i_ready || !r_ovalid ? S_OUT : S_FINAL;
            S_OUT:     n_st = S_IDLE;
            default:   n_st = S_IDLE;
        endcase
    end

    // memory port control
    always_comb begin
        adj_we = 1'b0;
        adj_addr = r_in.waiter;
        adj_wd = '0;
        prio_rd = 1'b0;
        case (r_st)
            S_CLR: begin
                adj_we = 1'b1;
                adj_addr = r_i[ID_W-1:0];
            end
            S_EDGE_WR: begin
                adj_we = 1'b1;
                adj_wd = r_adj_q;
                adj_wd[r_in.holder] = (r_in.kind == K_ADD);
            end
            S_TOP_RD: adj_addr = top;
            S_CYC_RD: begin
                adj_addr = r_stk[r_i[ID_W-1:0]];
                prio_rd = 1'b1;
            end
            S_DEL: begin
                adj_we = 1'b1;
                adj_addr = r_victim;
            end
            S_DEL_RD: adj_addr = r_i[ID_W-1:0];
            S_DEL_WR: begin
                adj_we = 1'b1;
                adj_addr = r_i[ID_W-1:0];
                adj_wd = r_adj_q;
                adj_wd[r_victim] = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adj_we) r_adj[adj_addr] <= adj_wd;
        r_adj_q <= r_adj[adj_addr];
        // the pass after reset also marks every priority absent
        if (r_st == S_CLR && r_init) r_prio[r_i[ID_W-1:0]] <= PRIO_ABSENT;
        else if (r_st == S_PRIO_WR) r_prio[r_in.waiter] <= r_in.priority_req;
        if (prio_rd) r_prio_q <= r_prio[r_stk[r_i[ID_W-1:0]]];
    end

    logic signed [31:0] p_s, b_s;
    assign p_s = r_prio_q;
    assign b_s = r_best;

    assign out_load = (r_st == S_EMIT || r_st == S_FINAL) && (i_ready || !r_ovalid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (out_load) r_ovalid <= 1'b1;
        else if (i_ready) r_ovalid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR;
            r_init <= 1'b1;
            r_len <= '0;
            r_vis <= '0;
            r_onp <= '0;
            r_i <= '0;
            r_start <= '0;
            r_cnt <= '0;
        end else begin
            r_st <= n_st;
            case (r_st)
                S_IDLE: begin
                    r_in <= i_data;
                    r_i <= '0;
                    r_start <= '0;
                    r_cnt <= '0;
                    r_len <= '0;
                    r_vis <= '0;
                    r_onp <= '0;
                end
                S_CLR: begin
                    r_i <= r_i + 1'b1;
                    if (r_i == (ID_W+1)'(NODES - 1)) r_init <= 1'b0;
                end
                S_START: begin
                    if (r_len == '0 && r_start != (ID_W+1)'(NODES)) begin
                        if (!r_vis[r_start[ID_W-1:0]]) begin
                            r_stk[0] <= r_start[ID_W-1:0];
                            r_cur[0] <= '0;
                            r_len <= (ID_W+1)'(1);
                            r_vis[r_start[ID_W-1:0]] <= 1'b1;
                            r_onp[r_start[ID_W-1:0]] <= 1'b1;
                        end
                        r_start <= r_start + 1'b1;
                    end
                end
                S_TOP_EV: begin
                    if (!found) begin
                        r_onp[top] <= 1'b0;
                        r_len <= r_len - 1'b1;
                    end else begin
                        r_cur[r_len[ID_W-1:0] - 1'b1] <= {1'b0, nb} + 1'b1;
                        if (!r_vis[nb]) begin
                            r_stk[r_len[ID_W-1:0]] <= nb;
                            r_cur[r_len[ID_W-1:0]] <= '0;
                            r_len <= r_len + 1'b1;
                            r_vis[nb] <= 1'b1;
                            r_onp[nb] <= 1'b1;
                        end else if (r_onp[nb]) begin
                            r_i <= first_idx;
                            r_cyc0 <= first_idx;
                        end
                    end
                end
                S_CYC_EV: begin
                    if (r_i == r_cyc0) begin
                        r_victim <= r_stk[r_i[ID_W-1:0]];
                        r_best <= r_prio_q;
                    end else if (p_s < b_s || (p_s == b_s &&
                                 r_stk[r_i[ID_W-1:0]] > r_victim)) begin
                        r_victim <= r_stk[r_i[ID_W-1:0]];
                        r_best <= r_prio_q;
                    end
                    r_i <= r_i + 1'b1;
                end
                S_EMIT: begin
                    if (out_load) begin
                        r_out <= '{1'b1, r_victim, r_best, 6'd0, 1'b0};
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DEL: r_i <= '0;
                S_DEL_WR: begin
                    r_i <= r_i + 1'b1;
                    if (r_i == (ID_W+1)'(NODES - 1)) begin
                        r_len <= '0;
                        r_vis <= '0;
                        r_onp <= '0;
                        r_start <= '0;
                    end
                end
                S_FINAL: begin
                    if (out_load)
                        r_out <= '{1'b0, 5'd0, 32'sd0, 6'(r_cnt), 1'b1};
                end
                default: ;
            endcase
        end
    end

    assign o_ready = (r_st == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result beat changed while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st != S_IDLE |-> !o_ready)
        else $error("ready while busy");
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= (ID_W+1)'(NODES))
        else $error("path overflow");
endmodule

>>> test/testbench.sv
// testbench: self-checking bench for the wait-for graph deadlock detector
// depends on wfg_pkg and wait_for_graph_deadlock_detector
// a graph model in the bench predicts victims, a checker compares each result beat
module testbench;
    import wfg_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 3000;
    localparam logic [2:0] K_SPARE_A = 3'd5;
    localparam logic [2:0] K_SPARE_B = 3'd6;
    localparam logic [2:0] K_SPARE_C = 3'd7;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_in  i_data;
    logic o_valid;
    logic i_ready;
    t_out o_data;

    wait_for_graph_deadlock_detector dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    // graph and priority copy kept by the bench
    logic [31:0]        wait_rows [NODES];
    logic signed [31:0] txn_prio [NODES];
    t_out               pending_victims [$];

    int errors;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;
    int quiet_cycles;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    function automatic bit find_loop(output int first, output int plen, output int stk [32]);
        bit [31:0] seen;
        bit [31:0] on_path;
        int cur [32];
        int top;
        int n;
        seen = '0;
        on_path = '0;
        plen = 0;
        first = 0;
        for (int s = 0; s < NODES; s++) begin
            if (seen[s]) continue;
            stk[0] = s;
            cur[0] = 0;
            plen = 1;
            seen[s] = 1'b1;
            on_path[s] = 1'b1;
            while (plen > 0) begin
                top = stk[plen-1];
                n = cur[plen-1];
                while (n < NODES && !wait_rows[top][n]) n++;
                if (n >= NODES) begin
                    on_path[top] = 1'b0;
                    plen--;
                    continue;
                end
                cur[plen-1] = n + 1;
                if (!seen[n]) begin
                    stk[plen] = n;
                    cur[plen] = 0;
                    plen++;
                    seen[n] = 1'b1;
                    on_path[n] = 1'b1;
                end else if (on_path[n]) begin
                    while (stk[first] != n) first++;
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic void predict_victims(t_in x);
        int first;
        int plen;
        int stk [32];
        int count;
        int victim;
        int m;
        t_out r;
        case (x.kind)
            K_CLEAR:  for (int i = 0; i < NODES; i++) wait_rows[i] = '0;
            K_ADD:    wait_rows[x.waiter][x.holder] = 1'b1;
            K_REMOVE: wait_rows[x.waiter][x.holder] = 1'b0;
            K_PRIO:   txn_prio[x.waiter] = x.priority_req;
            K_DETECT: begin
                count = 0;
                while (count < NODES && find_loop(first, plen, stk)) begin
                    victim = stk[first];
                    for (int i = first + 1; i < plen; i++) begin
                        m = stk[i];
                        // lowest priority wins, ties go to the higher id
                        if (txn_prio[m] < txn_prio[victim] ||
                            (txn_prio[m] == txn_prio[victim] && m > victim))
                            victim = m;
                    end
                    r = '0;
                    r.is_victim = 1'b1;
                    r.victim_id = victim[4:0];
                    r.victim_priority = txn_prio[victim];
                    pending_victims = {pending_victims, r};
                    wait_rows[victim] = '0;
                    for (int i = 0; i < NODES; i++) wait_rows[i][victim] = 1'b0;
                    count++;
                end
                r = '0;
                r.cycle_count = count[5:0];
                r.last = 1'b1;
                pending_victims = {pending_victims, r};
            end
            default: ;
        endcase
    endfunction

    // one input beat, held until accepted
    task automatic send(logic [2:0] kind, int w, int h, logic [31:0] prio);
        t_in x;
        bit seen_ready;
        x.kind = kind;
        x.waiter = w[4:0];
        x.holder = h[4:0];
        x.priority_req = prio;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= x;
        do begin
            @(negedge i_clk);
            seen_ready = o_ready;
            @(posedge i_clk);
        end while (!seen_ready);
        predict_victims(x);
    endtask

    task automatic go_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // receiver ready, with an optional long hold-off
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result checker, sampled mid-cycle so the values are those of the next edge
    always @(negedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_victims.size() == 0) begin
                report("unexpected beat", 64'(o_data), '0);
            end else begin
                want = pending_victims.pop_front();
                if (o_data.is_victim !== want.is_victim)
                    report("is_victim", 64'(o_data.is_victim), 64'(want.is_victim));
                if (o_data.victim_id !== want.victim_id)
                    report("victim_id", 64'(o_data.victim_id), 64'(want.victim_id));
                if (o_data.victim_priority !== want.victim_priority)
                    report("victim_priority", 64'(unsigned'(o_data.victim_priority)),
                           64'(unsigned'(want.victim_priority)));
                if (o_data.cycle_count !== want.cycle_count)
                    report("cycle_count", 64'(o_data.cycle_count), 64'(want.cycle_count));
                if (o_data.last !== want.last)
                    report("last", 64'(o_data.last), 64'(want.last));
            end
        end
    end

    always @(negedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("[wait_for_graph_deadlock_detector] ERROR");
            $finish;
        end
    end

    // load every priority, node 3 written back to absent
    task automatic test_load_priorities();
        for (int i = 0; i < NODES; i++)
            send(K_PRIO, i, 0, (i == 3) ? 32'h8000_0000 : $urandom);
    endtask

    task automatic test_directed();
        send(K_DETECT, 0, 0, 0);                  // empty graph
        send(K_ADD, 5, 5, 0);                     // self edge
        send(K_PRIO, 31, 0, 32'h7fff_ffff);
        send(K_PRIO, 30, 0, 32'h7fff_ffff);
        send(K_ADD, 31, 30, 0);                   // tie on priority, higher id wins
        send(K_ADD, 30, 31, 0);
        send(K_ADD, 0, 3, 0);                     // absent member in a three-node loop
        send(K_ADD, 3, 7, 0);
        send(K_ADD, 7, 0, 0);
        send(K_DETECT, 0, 0, 0);
        send(K_ADD, 1, 2, 0);
        send(K_ADD, 2, 1, 0);
        send(K_REMOVE, 2, 1, 0);
        send(K_DETECT, 0, 0, 0);
        send(K_ADD, 2, 1, 0);
        send(K_CLEAR, 0, 0, 0);
        send(K_SPARE_A, 2, 2, $urandom);          // unused kinds do nothing
        send(K_SPARE_B, 9, 9, $urandom);
        send(K_SPARE_C, 31, 31, $urandom);
        send(K_DETECT, 0, 0, 0);
        send(K_PRIO, 3, 0, 32'h8000_0000);
    endtask

    // every node waits on itself: 32 victims then the final beat
    task automatic test_max_victims();
        for (int i = 0; i < NODES; i++) send(K_ADD, i, i, 0);
        send(K_DETECT, 0, 0, 0);
    endtask

    task automatic test_random(int items);
        int pick;
        int span;
        for (int k = 0; k < items; k++) begin
            pick = $urandom_range(99);
            span = ($urandom_range(3) == 0) ? 31 : 7;
            if (pick < 45)
                send(K_ADD, $urandom_range(span), $urandom_range(span), $urandom);
            else if (pick < 58)
                send(K_REMOVE, $urandom_range(span), $urandom_range(span), $urandom);
            else if (pick < 72)
                send(K_PRIO, $urandom_range(31), $urandom_range(31),
                     ($urandom_range(4) == 0) ? {1'($urandom_range(1)), 31'h0} :
                                                 $urandom_range(15));
            else if (pick < 88)
                send(K_DETECT, $urandom_range(31), $urandom_range(31), $urandom);
            else if (pick < 93)
                send(K_CLEAR, $urandom_range(31), $urandom_range(31), $urandom);
            else
                send(3'($urandom_range(K_SPARE_C, K_SPARE_A)), $urandom_range(31),
                     $urandom_range(31), $urandom);
        end
    endtask

    // receiver stalls for a long stretch while detections keep coming
    task automatic test_backpressure();
        hold_cycles = 800;
        send(K_ADD, 4, 6, 0);
        send(K_ADD, 6, 4, 0);
        send(K_DETECT, 0, 0, 0);
        send(K_ADD, 8, 8, 0);
        send(K_DETECT, 0, 0, 0);
        send(K_DETECT, 0, 0, 0);
    endtask

    initial begin
        errors = 0;
        hold_cycles = 0;
        quiet_cycles = 0;
        send_idle_pct = 25;
        recv_idle_pct = 56;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_ready = 1'b0;
        for (int i = 0; i < NODES; i++) begin
            wait_rows[i] = '0;
            txn_prio[i] = 32'h8000_0000;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_load_priorities();
        test_directed();
        test_max_victims();
        test_random(70);
        test_backpressure();
        send_idle_pct = 56;
        recv_idle_pct = 25;
        test_random(70);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_max_victims();
        test_random(70);
        go_idle();

        while (pending_victims.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("[wait_for_graph_deadlock_detector] OK");
        else
            $display("[wait_for_graph_deadlock_detector] ERROR");
        $finish;
    end
endmodule

>>> files.f
rtl/core/wfg_pkg.sv
rtl/core/wfg_detector.sv
rtl/core/wait_for_graph_deadlock_detector.sv
test/testbench.sv
